/* hdl/fft_integer_convolution_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the integer convolution block
// Shared concurrent-assertion shorthands, reset gated.
// ---------------------------------------------------------------------------
`ifndef FFT_INTEGER_CONVOLUTION_ASSERT_SVH
`define FFT_INTEGER_CONVOLUTION_ASSERT_SVH

// same-cycle implication
`define FIC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FIC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fic_pkg.sv */
// ---------------------------------------------------------------------------
// fic_pkg
// Types and constants shared by the integer convolution block.
// ---------------------------------------------------------------------------
package fic_pkg;

  localparam int POINTS_DEF      = 1024;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COEF_W          = 42;
  localparam int LOG_W           = 4;
  localparam logic [LOG_W-1:0] LOG_SIZE_RST = 4'd10;

  typedef enum logic [1:0] {
    REQ_WR_A  = 2'd0,
    REQ_WR_B  = 2'd1,
    REQ_START = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // product issue to the operand memories
  typedef struct packed {
    logic valid;
    logic last;   // last term of the current coefficient
  } issue_t;

  // clearing sweep
  typedef struct packed {
    logic we;      // zero A and B at sweep address
    logic res_we;  // zero result entry too
  } sweep_t;

endpackage

/* hdl/fic_seq.sv */
// ---------------------------------------------------------------------------
// fic_seq
// Sequencer: coefficient/term loops of the convolution and clearing sweeps.
// ---------------------------------------------------------------------------
module fic_seq #(
  parameter int POINTS = fic_pkg::POINTS_DEF,
  parameter int AW     = $clog2(POINTS)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [fic_pkg::LOG_W-1:0] log_size,
  input  logic                     pipe_busy,
  output logic                     idle,
  output fic_pkg::issue_t          iss,
  output logic [AW-1:0]            k_addr,
  output logic [AW-1:0]            a_addr,
  output logic [AW-1:0]            b_addr,
  output fic_pkg::sweep_t          sw,
  output logic [AW-1:0]            sw_addr
);

  localparam int LGMAX = $clog2(POINTS + 1) - 1;

  fic_pkg::state_t state, state_next;
  logic [AW-1:0] kc, kc_next, jc, jc_next, mask, mask_next;
  logic          clr_all, clr_all_next;
  logic [fic_pkg::LOG_W:0] lg;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fic_pkg::ST_CLEAR;
      kc      <= '0;
      jc      <= '0;
      mask    <= '0;
      clr_all <= 1'b1;
    end else begin
      state   <= state_next;
      kc      <= kc_next;
      jc      <= jc_next;
      mask    <= mask_next;
      clr_all <= clr_all_next;
    end
  end

  always_comb begin
    lg = {1'b0, log_size};
    if (lg == '0) lg = (fic_pkg::LOG_W+1)'(1);
    if (int'(lg) > LGMAX) lg = (fic_pkg::LOG_W+1)'(LGMAX);
  end

  always_comb begin
    state_next   = state;
    kc_next      = kc;
    jc_next      = jc;
    mask_next    = mask;
    clr_all_next = clr_all;
    idle         = 1'b0;
    iss          = '0;
    sw           = '0;
    k_addr       = kc;
    a_addr       = kc - jc;
    b_addr       = jc;
    sw_addr      = kc;
    case (state)
      fic_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          mask_next  = AW'((32'd1 << lg) - 32'd1);
          kc_next    = '0;
          jc_next    = '0;
          state_next = fic_pkg::ST_RUN;
        end
      end
      fic_pkg::ST_RUN: begin
        a_addr    = (kc - jc) & mask;
        iss.valid = 1'b1;
        iss.last  = (jc == mask);
        if (jc == mask) begin
          jc_next = '0;
          if (kc == mask) begin
            state_next = fic_pkg::ST_DRAIN;
          end else begin
            kc_next = kc + 1'b1;
          end
        end else begin
          jc_next = jc + 1'b1;
        end
      end
      fic_pkg::ST_DRAIN: begin
        if (!pipe_busy) begin
          kc_next      = '0;
          clr_all_next = 1'b0;
          state_next   = fic_pkg::ST_CLEAR;
        end
      end
      fic_pkg::ST_CLEAR: begin
        sw.we     = 1'b1;
        sw.res_we = clr_all || (kc > mask);
        if (int'(kc) == POINTS - 1) begin
          kc_next    = '0;
          state_next = fic_pkg::ST_IDLE;
        end else begin
          kc_next = kc + 1'b1;
        end
      end
      default: state_next = fic_pkg::ST_IDLE;
    endcase
  end

endmodule

/* hdl/fic_mac.sv */
// ---------------------------------------------------------------------------
// fic_mac
// Operand memories A and B with the multiply-accumulate pipeline.
// ---------------------------------------------------------------------------
module fic_mac #(
  parameter int POINTS      = fic_pkg::POINTS_DEF,
  parameter int SAMPLE_BITS = fic_pkg::SAMPLE_BITS_DEF,
  parameter int AW          = $clog2(POINTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we_a,
  input  logic                       we_b,
  input  logic [AW-1:0]              waddr,
  input  logic [SAMPLE_BITS-1:0]     wdata,
  input  fic_pkg::sweep_t            sw,
  input  logic [AW-1:0]              sw_addr,
  input  fic_pkg::issue_t            iss,
  input  logic [AW-1:0]              k_addr,
  input  logic [AW-1:0]              a_addr,
  input  logic [AW-1:0]              b_addr,
  output logic                       busy,
  output logic                       res_we,
  output logic [AW-1:0]              res_addr,
  output logic [fic_pkg::COEF_W-1:0] res_data
);

  logic [SAMPLE_BITS-1:0] mem_a [POINTS];
  logic [SAMPLE_BITS-1:0] mem_b [POINTS];

  logic [SAMPLE_BITS-1:0]   a_q, b_q;
  logic [2*SAMPLE_BITS-1:0] prod;
  logic                     v1, l1, v2, l2;
  logic [AW-1:0]            k1, k2;
  logic [fic_pkg::COEF_W-1:0] acc, sum;

  // write ports: host load in idle, zero sweep afterwards
  always_ff @(posedge clk) begin
    if (sw.we) begin
      mem_a[sw_addr] <= '0;
      mem_b[sw_addr] <= '0;
    end else begin
      if (we_a) mem_a[waddr] <= wdata;
      if (we_b) mem_b[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    a_q  <= mem_a[a_addr];
    b_q  <= mem_b[b_addr];
    k1   <= k_addr;
    l1   <= iss.last;
    prod <= a_q * b_q;
    k2   <= k1;
    l2   <= l1;
  end

  assign sum = acc + fic_pkg::COEF_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      res_we <= 1'b0;
      acc    <= '0;
    end else begin
      v1     <= iss.valid;
      v2     <= v1;
      res_we <= v2 && l2;
      if (v2) acc <= l2 ? '0 : sum;
    end
  end

  always_ff @(posedge clk) begin
    res_addr <= k2;
    res_data <= sum;
  end

  assign busy = v1 || v2 || res_we;

endmodule

/* hdl/fft_integer_convolution.sv */
// ---------------------------------------------------------------------------
// fft_integer_convolution
// Circular integer convolution of two loaded sequences, coefficient readout.
// ---------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  req_type, index, sample
//  m_*      out  m_tvalid/m_tready  coefficient
//  cfg_*    in   cfg_we             log_size
//
//  Writes and starts complete on acceptance; a read presents its word
//  through the result memory read port and then the output reg.
//  A start runs S*S multiply-accumulate terms (S = 2^log_size, clamped
//  to 1..log2(POINTS)), one term per cycle through the A/B memory read
//  ports, then a drain, and a sweep that zeroes the operand stores and
//  result entries above S-1. After reset, a clearing pass over all
//  POINTS entries runs before s_tready rises. Input holds off the cycle
//  after a read, and while a read word waits on a stalled m_tready.
// ---------------------------------------------------------------------------
module fft_integer_convolution #(
  parameter int POINTS      = fic_pkg::POINTS_DEF,
  parameter int SAMPLE_BITS = fic_pkg::SAMPLE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [31:0]               s_tdata,  // req_type[1:0], index[11:2], sample[27:12]
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [47:0]               m_tdata,  // coefficient[41:0]
  input  logic                      cfg_we,
  input  logic [fic_pkg::LOG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(POINTS);

  logic [fic_pkg::LOG_W-1:0] log_size;
  logic [1:0]   req_type;
  logic [9:0]   index;
  logic [15:0]  sample;
  logic         acc_in, in_range, idle, busy;
  logic [AW-1:0] addr;

  fic_pkg::issue_t iss;
  fic_pkg::sweep_t sw;
  logic [AW-1:0] k_addr, a_addr, b_addr, sw_addr, res_addr;
  logic          res_we;
  logic [fic_pkg::COEF_W-1:0] res_data;

  logic [fic_pkg::COEF_W-1:0] mem_r [POINTS];
  logic [fic_pkg::COEF_W-1:0] rd_q;
  logic rd_pend, rd_zero;

  assign req_type = s_tdata[1:0];
  assign index    = s_tdata[11:2];
  assign sample   = s_tdata[27:12];
  assign addr     = AW'(index);
  assign in_range = (32'(index) < POINTS);

  assign s_tready = idle && !rd_pend && (!m_tvalid || m_tready);
  assign acc_in   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_size <= fic_pkg::LOG_SIZE_RST;
    end else if (cfg_we) begin
      log_size <= cfg_wdata;
    end
  end

  fic_seq #(.POINTS(POINTS), .AW(AW)) u_seq (
    .clk(clk), .rst(rst),
    .start(acc_in && req_type == fic_pkg::REQ_START),
    .log_size(log_size), .pipe_busy(busy), .idle(idle),
    .iss(iss), .k_addr(k_addr), .a_addr(a_addr), .b_addr(b_addr),
    .sw(sw), .sw_addr(sw_addr)
  );

  fic_mac #(.POINTS(POINTS), .SAMPLE_BITS(SAMPLE_BITS), .AW(AW)) u_mac (
    .clk(clk), .rst(rst),
    .we_a(acc_in && in_range && req_type == fic_pkg::REQ_WR_A),
    .we_b(acc_in && in_range && req_type == fic_pkg::REQ_WR_B),
    .waddr(addr), .wdata(SAMPLE_BITS'(sample)),
    .sw(sw), .sw_addr(sw_addr),
    .iss(iss), .k_addr(k_addr), .a_addr(a_addr), .b_addr(b_addr),
    .busy(busy), .res_we(res_we), .res_addr(res_addr), .res_data(res_data)
  );

  // result store: finished coefficients or zeroing sweep, never together
  always_ff @(posedge clk) begin
    if (res_we) begin
      mem_r[res_addr] <= res_data;
    end else if (sw.res_we) begin
      mem_r[sw_addr] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    rd_q    <= mem_r[addr];
    rd_zero <= !in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_pend <= acc_in && req_type == fic_pkg::REQ_READ;
      if (rd_pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) m_tdata <= 48'(rd_zero ? '0 : rd_q);
  end

`include "fft_integer_convolution_assert.svh"

  `FIC_ASSERT_NXT(a_rd_out, clk, rst, rd_pend, m_tvalid, "read word not presented")
  `FIC_ASSERT_IMP(a_rwr_excl, clk, rst, res_we, !sw.res_we, "result store double write")
  `FIC_ASSERT_IMP(a_busy_rdy, clk, rst, busy, !s_tready, "input taken while MAC busy")

endmodule
